FILE: src/lattice_bond_set_connectivity_top_assert.svh
// Assertion macros used by the checker file of the bond set connectivity block.
`ifndef LATTICE_BOND_SET_CONNECTIVITY_TOP_ASSERT_SVH
`define LATTICE_BOND_SET_CONNECTIVITY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbsc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbsc assertion failed");

`endif

FILE: src/lbsc_pkg.sv
// Package: sizes, codes and controller/datapath interface types of the bond set checker.
`default_nettype none
package lbsc_pkg;

    // Bonds kept per set and the site store that follows from it.
    localparam int MAX_BONDS = 16;
    localparam int SITE_CAP  = MAX_BONDS + 1;

    // A label runs 0..SITE_CAP, where SITE_CAP marks a site that did not fit.
    localparam int LAB_W  = $clog2(SITE_CAP + 1);
    localparam int SIDX_W = $clog2(SITE_CAP);
    localparam int BCNT_W = $clog2(MAX_BONDS + 1);
    localparam int BIDX_W = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;

    // Field widths.
    localparam int IN_W      = 8;
    localparam int COORD_W   = IN_W + 1;
    localparam int DIR_W     = 2;
    localparam int COUNT_W   = 5;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Bond direction codes.
    localparam logic [DIR_W-1:0] DIR_PX  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_PY  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_PXY = 2'd2;

    typedef struct packed {
        logic load_item;
        logic label_a;
        logic label_b;
        logic cl_init;
        logic cl_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic bond_room;
        logic last;
        logic overflow;
        logic scan_end;
        logic changed;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/lattice_bond_set_connectivity_top.sv
// Top level of the triangular-lattice bond set connectivity checker.
// The block takes the bonds of one cluster as a stream of items, each an origin site and a
// direction (+x, +y or +x+y), with tlast on the final bond of the set. Every new lattice site
// gets a label when first seen; up to MAX_BONDS bonds and MAX_BONDS+1 sites are kept per set,
// later bonds are dropped (their tlast still closes the set), and a site that does not fit
// marks the set as not connected with the site count reported as MAX_BONDS+1. After the
// last bond the block grows the reached set out from both ends of the first bond, one bond
// per cycle, sweeping the stored bonds until a full sweep adds nothing, and then emits one
// result item: the connected flag and the number of distinct sites; a set that overflowed
// skips the sweeps. A stored bond is accepted, then its origin is labeled, then its far end;
// a dropped bond is accepted and then dropped. The site lookup compares against all stored
// sites at once. The closure sweeps the stored bonds P times (P is at most the graph
// distance from the first bond plus one) and loads the result register once it is free.
// The result sits in an output register, so a new set can start while it waits to be taken.
// No input item is accepted while the closure runs. There is no clearing pass after reset.
`default_nettype none
module lattice_bond_set_connectivity_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] origin_x, [15:8] origin_y, [17:16] direction, [23:18] zero
    input  wire logic [lbsc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // last_bond
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] is_connected, [5:1] site_count, [7:6] zero
    output logic [lbsc_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import lbsc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller owns the sequence; the datapath holds all storage.
    lbsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lbsc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_data (s_axis_tdata),
        .i_item_last (s_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: src/lbsc_ctrl.sv
// Controller: sequences labeling of each bond and the reachability closure of a set.
`default_nettype none
module lbsc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lbsc_pkg::t_sts i_sts,
    output lbsc_pkg::t_cmd     o_cmd
);
    import lbsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LBL_A,
        S_LBL_B,
        S_CL_INIT,
        S_CL_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_LBL_A;
                end
            end
            S_LBL_A: begin
                // A bond beyond the store is dropped, but its last mark still counts.
                if (i_sts.bond_room) begin
                    o_cmd.label_a = 1'b1;
                    n_state       = S_LBL_B;
                end else begin
                    n_state = i_sts.last ? S_CL_INIT : S_IDLE;
                end
            end
            S_LBL_B: begin
                o_cmd.label_b = 1'b1;
                n_state       = i_sts.last ? S_CL_INIT : S_IDLE;
            end
            S_CL_INIT: begin
                o_cmd.cl_init = 1'b1;
                n_state       = i_sts.overflow ? S_FINISH : S_CL_SCAN;
            end
            S_CL_SCAN: begin
                o_cmd.cl_step = 1'b1;
                if (i_sts.scan_end && !i_sts.changed) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: src/lbsc_datapath.sv
// Datapath: site store with parallel lookup, bond end store, reached flags and result register.
`default_nettype none
module lbsc_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [lbsc_pkg::S_TDATA_W-1:0] i_item_data,
    input  wire logic                           i_item_last,
    input  wire lbsc_pkg::t_cmd                 i_cmd,
    output lbsc_pkg::t_sts                      o_sts,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [lbsc_pkg::M_TDATA_W-1:0]      o_out_data
);
    import lbsc_pkg::*;

    logic signed [COORD_W-1:0] r_site_x [SITE_CAP];
    logic signed [COORD_W-1:0] r_site_y [SITE_CAP];
    logic [LAB_W-1:0]          r_end_a  [MAX_BONDS];
    logic [LAB_W-1:0]          r_end_b  [MAX_BONDS];
    logic [SITE_CAP-1:0]       r_reached;
    logic [LAB_W-1:0]          r_sites;
    logic [BCNT_W-1:0]         r_bonds;
    logic                      r_overflow;
    logic signed [COORD_W-1:0] r_ox, r_oy, r_fx, r_fy;
    logic                      r_last;
    logic [LAB_W-1:0]          r_lab_a;
    logic [BIDX_W-1:0]         r_idx;
    logic                      r_changed;
    logic                      r_out_valid;
    logic                      r_out_conn;
    logic [COUNT_W-1:0]        r_out_count;

    // Incoming item decode.
    logic signed [COORD_W-1:0] in_x, in_y, in_fx, in_fy;
    logic [DIR_W-1:0]          in_dir;

    // Site lookup.
    logic signed [COORD_W-1:0] key_x, key_y;
    logic                      hit;
    logic [LAB_W-1:0]          hit_lab;
    logic                      new_room;
    logic [LAB_W-1:0]          lab;

    // Closure step.
    logic [LAB_W-1:0]          cur_a, cur_b;
    logic                      pair_ok;
    logic                      flag_a, flag_b;
    logic                      step_change;
    logic [SITE_CAP-1:0]       step_mask;
    logic                      scan_end;

    // Result.
    logic [SITE_CAP-1:0]       site_mask;
    logic                      all_reached;
    logic                      conn;
    logic [LAB_W-1:0]          count_full;
    logic [COUNT_W-1:0]        count_sat;
    logic [SITE_CAP-1:0]       init_flags;

    always_comb begin
        in_x   = {i_item_data[IN_W-1], i_item_data[IN_W-1:0]};
        in_y   = {i_item_data[2*IN_W-1], i_item_data[2*IN_W-1:IN_W]};
        in_dir = i_item_data[2*IN_W+DIR_W-1:2*IN_W];
        in_fx  = in_x;
        in_fy  = in_y;
        if (in_dir == DIR_PX || in_dir == DIR_PXY) begin
            in_fx = in_x + COORD_W'(1);
        end
        if (in_dir == DIR_PY || in_dir == DIR_PXY) begin
            in_fy = in_y + COORD_W'(1);
        end
    end

    // Compare the key against every stored site at once; lowest label wins.
    always_comb begin
        key_x   = i_cmd.label_b ? r_fx : r_ox;
        key_y   = i_cmd.label_b ? r_fy : r_oy;
        hit     = 1'b0;
        hit_lab = '0;
        for (int k = 0; k < SITE_CAP; k++) begin
            if (!hit && (LAB_W'(k) < r_sites) && r_site_x[k] == key_x
                && r_site_y[k] == key_y) begin
                hit     = 1'b1;
                hit_lab = LAB_W'(k);
            end
        end
        new_room = r_sites < LAB_W'(SITE_CAP);
        if (hit) begin
            lab = hit_lab;
        end else if (new_room) begin
            lab = r_sites;
        end else begin
            lab = LAB_W'(SITE_CAP);
        end
    end

    always_comb begin
        cur_a       = r_end_a[r_idx];
        cur_b       = r_end_b[r_idx];
        pair_ok     = (cur_a < LAB_W'(SITE_CAP)) && (cur_b < LAB_W'(SITE_CAP));
        flag_a      = r_reached[cur_a[SIDX_W-1:0]];
        flag_b      = r_reached[cur_b[SIDX_W-1:0]];
        step_change = pair_ok && (flag_a != flag_b);
        scan_end    = BCNT_W'(r_idx) == (r_bonds - BCNT_W'(1));
        // Both ends of a bond that joins a reached and an unreached site become reached.
        step_mask   = '0;
        if (step_change) begin
            step_mask[cur_a[SIDX_W-1:0]] = 1'b1;
            step_mask[cur_b[SIDX_W-1:0]] = 1'b1;
        end
    end

    always_comb begin
        init_flags = '0;
        if (r_end_a[0] < LAB_W'(SITE_CAP)) begin
            init_flags[r_end_a[0][SIDX_W-1:0]] = 1'b1;
        end
        if (r_end_b[0] < LAB_W'(SITE_CAP)) begin
            init_flags[r_end_b[0][SIDX_W-1:0]] = 1'b1;
        end
    end

    always_comb begin
        for (int k = 0; k < SITE_CAP; k++) begin
            site_mask[k] = LAB_W'(k) < r_sites;
        end
        all_reached = &(r_reached | ~site_mask);
        conn        = !r_overflow && (r_bonds != '0) && all_reached;
        count_full  = r_overflow ? LAB_W'(SITE_CAP) : r_sites;
        if (int'(count_full) > COUNT_MAX) begin
            count_sat = COUNT_W'(COUNT_MAX);
        end else begin
            count_sat = COUNT_W'(count_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sites     <= '0;
            r_bonds     <= '0;
            r_overflow  <= 1'b0;
            r_idx       <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.load_item) begin
                r_ox   <= in_x;
                r_oy   <= in_y;
                r_fx   <= in_fx;
                r_fy   <= in_fy;
                r_last <= i_item_last;
            end

            if (i_cmd.label_a || i_cmd.label_b) begin
                if (!hit && new_room) begin
                    r_site_x[r_sites[SIDX_W-1:0]] <= key_x;
                    r_site_y[r_sites[SIDX_W-1:0]] <= key_y;
                    r_sites <= r_sites + LAB_W'(1);
                end
                if (!hit && !new_room) begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.label_a) begin
                r_lab_a <= lab;
            end
            if (i_cmd.label_b) begin
                r_end_a[r_bonds[BIDX_W-1:0]] <= r_lab_a;
                r_end_b[r_bonds[BIDX_W-1:0]] <= lab;
                r_bonds <= r_bonds + BCNT_W'(1);
            end

            if (i_cmd.cl_init) begin
                r_reached <= init_flags;
                r_idx     <= '0;
                r_changed <= 1'b0;
            end

            if (i_cmd.cl_step) begin
                r_reached <= r_reached | step_mask;
                if (scan_end) begin
                    r_idx     <= '0;
                    r_changed <= 1'b0;
                end else begin
                    r_idx     <= r_idx + BIDX_W'(1);
                    r_changed <= r_changed | step_change;
                end
            end

            if (i_cmd.finish) begin
                r_out_conn  <= conn;
                r_out_count <= count_sat;
                r_sites     <= '0;
                r_bonds     <= '0;
                r_overflow  <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.bond_room = r_bonds < BCNT_W'(MAX_BONDS);
        o_sts.last      = r_last;
        o_sts.overflow  = r_overflow;
        o_sts.scan_end  = scan_end;
        o_sts.changed   = r_changed | step_change;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(M_TDATA_W - COUNT_W - 1){1'b0}}, r_out_count, r_out_conn};

endmodule
`default_nettype wire

FILE: src/lbsc_checker.sv
// Port-level checker for the bond set connectivity block, bound to the top level.
`default_nettype none
`include "lattice_bond_set_connectivity_top_assert.svh"
module lbsc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [lbsc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import lbsc_pkg::*;

    logic [COUNT_W-1:0] out_count;
    logic               in_acc;

    assign out_count = m_axis_tdata[COUNT_W:1];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    // A held result keeps its value until taken.
    `LBSC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Every reported site count is at least one and never more than SITE_CAP.
    `LBSC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, m_axis_tvalid, out_count >= COUNT_W'(1) && out_count <= COUNT_W'(SITE_CAP))

    // The input is not ready right after an item is accepted, while its bond is labeled.
    `LBSC_ASSERT_NXT(a_busy_after_item, i_clk, i_rst_n, in_acc, !s_axis_tready)

    // A new result is loaded only while the input side is held off.
    `LBSC_ASSERT_IMP(a_result_when_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind lattice_bond_set_connectivity_top lbsc_checker u_lbsc_checker (.*);
`default_nettype wire
